[hdl/sprpt_pkg.sv]
// Shared widths, codes and types for the support region point test.
`default_nettype none

package sprpt_pkg;

   // Field widths
   localparam int POINT_W     = 32;
   localparam int TRIG_W      = 16;
   localparam int SEMI_W      = 24;
   localparam int TAN_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Pipeline depth in register stages
   localparam int NUM_STAGES = 9;

   typedef logic [1:0]             quad_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Local quadrant codes
   localparam quad_type QUAD_FIRST  = 2'd0;
   localparam quad_type QUAD_SECOND = 2'd1;
   localparam quad_type QUAD_THIRD  = 2'd2;
   localparam quad_type QUAD_FOURTH = 2'd3;

   // Register indexes
   localparam csr_index_type CSR_SEMI_SIDE  = 3'd0;
   localparam csr_index_type CSR_SEMI_FRONT = 3'd1;
   localparam csr_index_type CSR_SEMI_BACK  = 3'd2;
   localparam csr_index_type CSR_TAN_FRONT  = 3'd3;
   localparam csr_index_type CSR_TAN_BACK   = 3'd4;

   // Register reset values
   localparam logic [SEMI_W-1:0] SEMI_RESET = 24'd65536;
   localparam logic [TAN_W-1:0]  TAN_RESET  = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[hdl/sprpt_req_if.sv]
// Request channel: candidate point, region pose and moving foot.
`default_nettype none

interface sprpt_req_if
   import sprpt_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic signed [POINT_W-1:0] center_x;
   logic signed [POINT_W-1:0] center_y;
   logic signed [TRIG_W-1:0]  region_cos;
   logic signed [TRIG_W-1:0]  region_sin;
   logic                      right_foot;

   modport source (
      output valid, point_x, point_y, center_x, center_y,
             region_cos, region_sin, right_foot,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, center_x, center_y,
             region_cos, region_sin, right_foot,
      output ready
   );
endinterface

`default_nettype wire

[hdl/sprpt_rsp_if.sv]
// Response channel: inside flag and local quadrant.
`default_nettype none

interface sprpt_rsp_if
   import sprpt_pkg::*;
   ();
   logic     valid;
   logic     ready;
   logic     inside_res;
   quad_type quadrant;

   modport source (
      output valid, inside_res, quadrant,
      input  ready
   );

   modport sink (
      input  valid, inside_res, quadrant,
      output ready
   );
endinterface

`default_nettype wire

[hdl/support_region_point_test.sv]
// Pipelined test of a foot point against an elliptic support region.
//
// Usage: a request transaction on req_ch carries the candidate point, the
// region centre, the region orientation as cosine and sine (Q1.15) and the
// moving foot. Each request gives exactly one response transaction on rsp_ch
// with the inside flag and the local quadrant, in request order.
// The pipeline has nine register stages, from the centre offset to the
// output register; one request can be taken every cycle while rsp_ch
// takes the responses.
// The depth is set by the rotation multipliers, the ellipse products and the
// 63-bit squares, which are built from 32x32 partial products and summed in
// stages of their own.
// Each stage holds its item while the one ahead is full and stalled, so
// empty stages fill in when rsp_ch stalls; req_ch.ready drops only when
// all nine stages hold an item and the response is not taken.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers: semi-axes 1.0 m, tangent limits all ones (no angle limit).
// Write the five registers via csr_wr_en/csr_index/csr_wdata only
// while no transaction is in flight (unenforced); other indexes are ignored.
`default_nettype none

module support_region_point_test
   import sprpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   sprpt_req_if.sink                  req_ch,
   sprpt_rsp_if.source                rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [SEMI_W-1:0] semi_side_ff, semi_front_ff, semi_back_ff;
   logic [TAN_W-1:0]  tan_front_ff, tan_back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_side_ff  <= SEMI_RESET;
         semi_front_ff <= SEMI_RESET;
         semi_back_ff  <= SEMI_RESET;
         tan_front_ff  <= TAN_RESET;
         tan_back_ff   <= TAN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SEMI_SIDE:  semi_side_ff  <= csr_wdata[SEMI_W-1:0];
            CSR_SEMI_FRONT: semi_front_ff <= csr_wdata[SEMI_W-1:0];
            CSR_SEMI_BACK:  semi_back_ff  <= csr_wdata[SEMI_W-1:0];
            CSR_TAN_FRONT:  tan_front_ff  <= csr_wdata[TAN_W-1:0];
            CSR_TAN_BACK:   tan_back_ff   <= csr_wdata[TAN_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage valid bits and enables: a stage loads when empty or when the
   // stage ahead of it moves on
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in, en;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_ch.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ch.ready = en[0];

   // ------------------------------------------------------------------
   // Stage 0: offset from the region centre
   // ------------------------------------------------------------------
   logic signed [POINT_W:0]   xc_ff, yc_ff;
   logic signed [TRIG_W-1:0]  cos_ff, sin_ff;
   logic                      right0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xc_ff     <= (POINT_W+1)'(req_ch.point_x) - (POINT_W+1)'(req_ch.center_x);
         yc_ff     <= (POINT_W+1)'(req_ch.point_y) - (POINT_W+1)'(req_ch.center_y);
         cos_ff    <= req_ch.region_cos;
         sin_ff    <= req_ch.region_sin;
         right0_ff <= req_ch.right_foot;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: rotation products
   // ------------------------------------------------------------------
   logic signed [48:0] p_xc_ff, p_ys_ff, p_xs_ff, p_yc_ff;
   logic               right1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_xc_ff   <= xc_ff * cos_ff;
         p_ys_ff   <= yc_ff * sin_ff;
         p_xs_ff   <= xc_ff * sin_ff;
         p_yc_ff   <= yc_ff * cos_ff;
         right1_ff <= right0_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: rotated offset, 31 fraction bits
   // ------------------------------------------------------------------
   logic signed [49:0] x_ff, y_ff;
   logic               right2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         x_ff      <= 50'(p_xc_ff) - 50'(p_ys_ff);
         y_ff      <= 50'(p_xs_ff) + 50'(p_yc_ff);
         right2_ff <= right1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: magnitudes and signs
   // ------------------------------------------------------------------
   logic [49:0] ax_ff, ay_ff;
   logic        xneg_ff, yneg_ff, right3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ax_ff     <= x_ff[49] ? 50'(-x_ff) : 50'(x_ff);
         ay_ff     <= y_ff[49] ? 50'(-y_ff) : 50'(y_ff);
         xneg_ff   <= x_ff[49];
         yneg_ff   <= y_ff[49];
         right3_ff <= right2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: bounds, ellipse terms and tangent products.
   // When the point passes the bounds both magnitudes fit in 39 bits, so
   // the products use only those bits.
   // ------------------------------------------------------------------
   logic [SEMI_W-1:0] semi_m;
   logic [TAN_W-1:0]  tan_t;
   logic [47:0]       sm_prod;
   logic              over_in;
   quad_type          quad_in;

   always_comb begin
      semi_m  = yneg_ff ? semi_back_ff : semi_front_ff;
      tan_t   = yneg_ff ? tan_back_ff : tan_front_ff;
      sm_prod = 48'(semi_side_ff) * 48'(semi_m);
      over_in = (semi_side_ff == '0) || (semi_m == '0)
             || (ax_ff > 50'({semi_side_ff, 15'b0}))
             || (ay_ff > 50'({semi_m, 15'b0}));
      if (!yneg_ff) begin
         quad_in = xneg_ff ? QUAD_SECOND : QUAD_FIRST;
      end else begin
         quad_in = xneg_ff ? QUAD_THIRD : QUAD_FOURTH;
      end
   end

   logic [62:0] term_a_ff, term_b_ff, term_c_ff;
   logic [38:0] tay_hi_ff;
   logic [63:0] tay_lo_ff;
   logic [54:0] ang_lhs4_ff;
   logic        over4_ff, inner4_ff, nolim4_ff;
   quad_type    quad4_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         term_a_ff   <= 63'(ax_ff[38:0]) * 63'(semi_m);
         term_b_ff   <= 63'(ay_ff[38:0]) * 63'(semi_side_ff);
         term_c_ff   <= {sm_prod, 15'b0};
         tay_hi_ff   <= 39'(tan_t) * 39'(ay_ff[38:32]);
         tay_lo_ff   <= 64'(tan_t) * 64'(ay_ff[31:0]);
         ang_lhs4_ff <= {ax_ff[38:0], 16'b0};
         over4_ff    <= over_in;
         inner4_ff   <= right3_ff ? xneg_ff : !xneg_ff;
         nolim4_ff   <= (tan_t == '1);
         quad4_ff    <= quad_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: 32x32 partial products of the three squares, tangent sum
   // ------------------------------------------------------------------
   logic [62:0] sq_src [3];
   logic [61:0] hh_ff  [3];
   logic [62:0] hl_ff  [3];
   logic [63:0] ll_ff  [3];
   logic [70:0] tay_ff;
   logic [54:0] ang_lhs5_ff;
   logic        over5_ff, inner5_ff, nolim5_ff;
   quad_type    quad5_ff;

   always_comb begin
      sq_src[0] = term_a_ff;
      sq_src[1] = term_b_ff;
      sq_src[2] = term_c_ff;
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= 62'(sq_src[i][62:32]) * 62'(sq_src[i][62:32]);
            hl_ff[i] <= 63'(sq_src[i][62:32]) * 63'(sq_src[i][31:0]);
            ll_ff[i] <= 64'(sq_src[i][31:0]) * 64'(sq_src[i][31:0]);
         end
         tay_ff      <= {tay_hi_ff, 32'b0} + 71'(tay_lo_ff);
         ang_lhs5_ff <= ang_lhs4_ff;
         over5_ff    <= over4_ff;
         inner5_ff   <= inner4_ff;
         nolim5_ff   <= nolim4_ff;
         quad5_ff    <= quad4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: assemble squares, angle compare
   // ------------------------------------------------------------------
   logic [125:0] sq_ff [3];
   logic         ang_ok6_ff, over6_ff, inner6_ff;
   quad_type     quad6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= {hh_ff[i], 64'b0} + 126'({hl_ff[i], 33'b0}) + 126'(ll_ff[i]);
         end
         ang_ok6_ff <= nolim5_ff || (71'(ang_lhs5_ff) <= tay_ff);
         over6_ff   <= over5_ff;
         inner6_ff  <= inner5_ff;
         quad6_ff   <= quad5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: left-hand side of the ellipse test
   // ------------------------------------------------------------------
   logic [126:0] lhs_ff;
   logic [125:0] rhs_ff;
   logic         ang_ok7_ff, over7_ff, inner7_ff;
   quad_type     quad7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         lhs_ff     <= 127'(sq_ff[0]) + 127'(sq_ff[1]);
         rhs_ff     <= sq_ff[2];
         ang_ok7_ff <= ang_ok6_ff;
         over7_ff   <= over6_ff;
         inner7_ff  <= inner6_ff;
         quad7_ff   <= quad6_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8: final decision, output register
   // ------------------------------------------------------------------
   logic     inside_res_ff;
   quad_type quadrant_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         inside_res_ff <= !over7_ff && (lhs_ff <= 127'(rhs_ff))
                       && (!inner7_ff || ang_ok7_ff);
         quadrant_ff   <= quad7_ff;
      end
   end

   assign rsp_ch.valid      = valid_ff[NUM_STAGES-1];
   assign rsp_ch.inside_res = inside_res_ff;
   assign rsp_ch.quadrant   = quadrant_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Requests are refused only when the pipeline is full and stalled
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (valid_ff == '1) && !rsp_ch.ready)
      else $error("request refused while a stage is free");

   // A zero side semi-axis always marks the point out of bounds
   a_zero_side_over: assert property (@(posedge clock) disable iff (reset)
      (en[4] && valid_ff[3] && semi_side_ff == '0) |=> over4_ff)
      else $error("zero side semi-axis not flagged");

   // An out-of-bounds point never reports inside
   a_over_not_inside: assert property (@(posedge clock) disable iff (reset)
      (en[8] && valid_ff[7] && over7_ff) |=> !inside_res_ff)
      else $error("out-of-bounds point reported inside");

   // Reset empties the pipeline
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the support region point test pipeline.
`timescale 1ns / 1ps

module tb;
   import sprpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES  = 12;
   localparam int POINTS_PER_PHASE = 155;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};
   localparam logic signed [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
   localparam logic signed [TRIG_W-1:0]  TRIG_MIN  = {1'b1, {(TRIG_W-1){1'b0}}};
   localparam logic signed [TRIG_W-1:0]  TRIG_MAX  = {1'b0, {(TRIG_W-1){1'b1}}};
   localparam logic signed [TRIG_W-1:0]  TRIG_ZERO = '0;
   localparam int ONE_M = 65536;
   localparam int SEMI_MAX = (1 << SEMI_W) - 1;
   localparam int CSR_INDEX_TOP = (1 << CSR_INDEX_W) - 1;

   typedef struct {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic signed [POINT_W-1:0] center_x;
      logic signed [POINT_W-1:0] center_y;
      logic signed [TRIG_W-1:0]  region_cos;
      logic signed [TRIG_W-1:0]  region_sin;
      logic                      right_foot;
   } foot_point_type;

   typedef struct {
      logic     inside_res;
      quad_type quadrant;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sprpt_req_if req_ch ();
   sprpt_rsp_if rsp_ch ();

   support_region_point_test i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the region registers
   logic [SEMI_W-1:0] side_axis_cfg;
   logic [SEMI_W-1:0] front_axis_cfg;
   logic [SEMI_W-1:0] back_axis_cfg;
   logic [TAN_W-1:0]  front_tan_cfg;
   logic [TAN_W-1:0]  back_tan_cfg;

   foot_point_type pending_points[$];
   verdict_type    expected_verdicts[$];
   foot_point_type cur_point;
   verdict_type    want_verdict;
   int             err_count;
   int             stall_cycles;
   int             send_idle_pct;
   int             recv_stall_pct;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Expected verdict: rotate the offset into the region frame, then apply
   // the half-ellipse test and, on the inner side, the tangent bound.
   function automatic verdict_type classify_point(input foot_point_type p);
      longint       dx;
      longint       dy;
      longint       rx;
      longint       ry;
      logic [127:0] ax;
      logic [127:0] ay;
      logic [127:0] side;
      logic [127:0] half;
      logic [127:0] tan_lim;
      logic [TAN_W-1:0] tan_reg;
      logic         inner;
      verdict_type  v;
      dx = longint'(p.point_x) - longint'(p.center_x);
      dy = longint'(p.point_y) - longint'(p.center_y);
      rx = dx * longint'(p.region_cos) - dy * longint'(p.region_sin);
      ry = dx * longint'(p.region_sin) + dy * longint'(p.region_cos);
      if (rx < 0) ax = 128'(-rx);
      else ax = 128'(rx);
      if (ry < 0) ay = 128'(-ry);
      else ay = 128'(ry);
      side = 128'(side_axis_cfg);
      half = (ry < 0) ? 128'(back_axis_cfg) : 128'(front_axis_cfg);
      tan_reg = (ry < 0) ? back_tan_cfg : front_tan_cfg;
      tan_lim = 128'(tan_reg);
      if (ry >= 0) v.quadrant = (rx < 0) ? QUAD_SECOND : QUAD_FIRST;
      else v.quadrant = (rx < 0) ? QUAD_THIRD : QUAD_FOURTH;
      // bounding box first keeps every square within 128 bits
      if (side == 0 || half == 0 || ax > (side << 15) || ay > (half << 15)) begin
         v.inside_res = 1'b0;
      end else begin
         v.inside_res = ((ax * half) * (ax * half) + (ay * side) * (ay * side))
                        <= (((side * half) << 15) * ((side * half) << 15));
      end
      inner = p.right_foot ? (rx < 0) : (rx >= 0);
      if (v.inside_res && inner && tan_reg != {TAN_W{1'b1}}) begin
         v.inside_res = (ax << 16) <= (tan_lim * ay);
      end
      return v;
   endfunction

   task automatic add_point(input logic signed [POINT_W-1:0] px, py, cx, cy,
                            input logic signed [TRIG_W-1:0] c, s, input logic rf);
      foot_point_type p;
      p.point_x    = px;
      p.point_y    = py;
      p.center_x   = cx;
      p.center_y   = cy;
      p.region_cos = c;
      p.region_sin = s;
      p.right_foot = rf;
      pending_points = {pending_points, p};
   endtask

   // Mostly points near the region with a true unit rotation; some with
   // arbitrary cos/sin, some fully random.
   task automatic make_random_point(output foot_point_type p);
      int unsigned kind;
      longint      reach;
      longint      dx;
      longint      dy;
      real         theta;
      kind = $urandom_range(99);
      p.point_x    = $urandom;
      p.point_y    = $urandom;
      p.center_x   = $urandom;
      p.center_y   = $urandom;
      p.region_cos = 16'($urandom);
      p.region_sin = 16'($urandom);
      p.right_foot = 1'($urandom);
      if (kind < 90) begin
         reach = longint'(side_axis_cfg);
         if (longint'(front_axis_cfg) > reach) reach = longint'(front_axis_cfg);
         if (longint'(back_axis_cfg) > reach) reach = longint'(back_axis_cfg);
         reach = reach + reach / 2 + 4;
         dx = longint'($urandom_range(0, 32'(2 * reach))) - reach;
         dy = longint'($urandom_range(0, 32'(2 * reach))) - reach;
         p.center_x = $signed($urandom) >>> 1;
         p.center_y = $signed($urandom) >>> 1;
         p.point_x  = 32'(longint'(p.center_x) + dx);
         p.point_y  = 32'(longint'(p.center_y) + dy);
         if (kind < 80) begin
            theta = $urandom_range(0, 35999) * 6.283185307179586 / 36000.0;
            p.region_cos = 16'($rtoi($cos(theta) * 32767.0));
            p.region_sin = 16'($rtoi($sin(theta) * 32767.0));
         end
      end
   endtask

   function automatic logic [SEMI_W-1:0] pick_semi_axis();
      case ($urandom_range(11))
         0: return '0;
         1: return SEMI_W'(1);
         2: return '1;
         default: return SEMI_W'($urandom_range(3277, 262144));
      endcase
   endfunction

   function automatic logic [TAN_W-1:0] pick_tan_limit();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'hFFFF_FFFE;
         3: return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   // Register write, left asserted until csr_idle; semi-axis writes carry
   // junk in the unused upper bits.
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = value;
      if (idx <= CSR_SEMI_BACK) data[CSR_DATA_W-1:SEMI_W] = (CSR_DATA_W-SEMI_W)'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SEMI_SIDE:  side_axis_cfg  = data[SEMI_W-1:0];
         CSR_SEMI_FRONT: front_axis_cfg = data[SEMI_W-1:0];
         CSR_SEMI_BACK:  back_axis_cfg  = data[SEMI_W-1:0];
         CSR_TAN_FRONT:  front_tan_cfg  = data[TAN_W-1:0];
         CSR_TAN_BACK:   back_tan_cfg   = data[TAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drain();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_ch.valid || expected_verdicts.size() != 0);
   endtask

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_verdicts = {expected_verdicts, classify_point(cur_point)};
         end
         if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_point = pending_points.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.point_x    <= cur_point.point_x;
            req_ch.point_y    <= cur_point.point_y;
            req_ch.center_x   <= cur_point.center_x;
            req_ch.center_y   <= cur_point.center_y;
            req_ch.region_cos <= cur_point.region_cos;
            req_ch.region_sin <= cur_point.region_sin;
            req_ch.right_foot <= cur_point.right_foot;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_verdicts.size() == 0) begin
            note_error($sformatf("unexpected response: inside=%0d quadrant=%0d",
                                 rsp_ch.inside_res, rsp_ch.quadrant));
         end else begin
            want_verdict = expected_verdicts.pop_front();
            if (rsp_ch.inside_res !== want_verdict.inside_res ||
                rsp_ch.quadrant !== want_verdict.quadrant) begin
               note_error($sformatf(
                  "mismatch: expected inside=%0d quadrant=%0d, got inside=%0d quadrant=%0d",
                  want_verdict.inside_res, want_verdict.quadrant,
                  rsp_ch.inside_res, rsp_ch.quadrant));
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      int             phase;
      int             n;
      int             k;
      foot_point_type p;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.point_x    = '0;
      req_ch.point_y    = '0;
      req_ch.center_x   = '0;
      req_ch.center_y   = '0;
      req_ch.region_cos = '0;
      req_ch.region_sin = '0;
      req_ch.right_foot = 1'b0;
      rsp_ch.ready      = 1'b0;
      err_count         = 0;
      stall_cycles      = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      side_axis_cfg     = SEMI_RESET;
      front_axis_cfg    = SEMI_RESET;
      back_axis_cfg     = SEMI_RESET;
      front_tan_cfg     = TAN_RESET;
      back_tan_cfg      = TAN_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: centre, ellipse boundaries, quadrants, field extremes
      add_point(0, 0, 0, 0, TRIG_ZERO, TRIG_ZERO, 1'b0);
      add_point(12345, -777, 12345, -777, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(1000 - ONE_M, 2000, 1000, 2000, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(1000 - ONE_M - 1, 2000, 1000, 2000, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(1000 + ONE_M, 2000, 1000, 2000, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(0, -ONE_M, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(0, ONE_M, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(0, ONE_M + 1, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(30000, 30000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(POINT_MAX, POINT_MIN, POINT_MIN, POINT_MAX, TRIG_MIN, TRIG_MIN, 1'b1);
      add_point(POINT_MIN, POINT_MAX, POINT_MAX, POINT_MIN, TRIG_MAX, TRIG_MAX, 1'b0);
      add_point(POINT_MAX, POINT_MAX, POINT_MAX, POINT_MAX, TRIG_MAX, TRIG_MIN, 1'b1);
      add_point(POINT_MIN, POINT_MIN, POINT_MIN, POINT_MIN, TRIG_MIN, TRIG_MAX, 1'b0);
      add_point(-5000, 7000, 0, 0, TRIG_MAX, TRIG_ZERO, 1'b0);
      wait_drain();

      // Angle limits: front tangent 1.0, back tangent zero
      csr_write(CSR_SEMI_SIDE, ONE_M);
      csr_write(CSR_TAN_FRONT, ONE_M);
      csr_write(CSR_TAN_BACK, '0);
      csr_idle();
      add_point(-20000, -20000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(-20001, -20000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(-20000, 0, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(-20000, 0, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(0, 20000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(-1, 20000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(1000, 1000, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      wait_drain();

      // Zero side axis; writes to unused indexes must change nothing
      csr_write(CSR_SEMI_SIDE, '0);
      for (k = CSR_TAN_BACK + 1; k <= CSR_INDEX_TOP; k++)
         csr_write(csr_index_type'(k), $urandom);
      csr_idle();
      add_point(0, 0, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      add_point(-100, -100, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      wait_drain();

      // Widest side axis, zero front axis
      csr_write(CSR_SEMI_SIDE, SEMI_MAX);
      csr_write(CSR_SEMI_FRONT, '0);
      csr_idle();
      add_point(0, -100, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(0, 100, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      wait_drain();

      // All axes at maximum, front tangent one step below no-limit
      csr_write(CSR_SEMI_FRONT, SEMI_MAX);
      csr_write(CSR_SEMI_BACK, SEMI_MAX);
      csr_write(CSR_TAN_FRONT, 32'hFFFF_FFFE);
      csr_write(CSR_TAN_BACK, TAN_RESET);
      csr_idle();
      add_point(-SEMI_MAX, 0, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b1);
      add_point(-20000, 0, 0, 0, TRIG_MIN, TRIG_ZERO, 1'b0);
      wait_drain();

      // Random phases: fresh registers each time and one of four idling patterns in turn
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         csr_write(CSR_SEMI_SIDE, CSR_DATA_W'(pick_semi_axis()));
         csr_write(CSR_SEMI_FRONT, CSR_DATA_W'(pick_semi_axis()));
         csr_write(CSR_SEMI_BACK, CSR_DATA_W'(pick_semi_axis()));
         csr_write(CSR_TAN_FRONT, pick_tan_limit());
         csr_write(CSR_TAN_BACK, pick_tan_limit());
         csr_idle();
         @(negedge clock);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (n = 0; n < POINTS_PER_PHASE; n++) begin
            make_random_point(p);
            pending_points = {pending_points, p};
         end
         wait_drain();
      end

      repeat (NUM_STAGES + 4) @(posedge clock);
      err_count += expected_verdicts.size();
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
hdl/sprpt_pkg.sv
hdl/sprpt_req_if.sv
hdl/sprpt_rsp_if.sv
hdl/support_region_point_test.sv
sim/tb.sv
